// File: src/ppu_pkg.sv
// Shared types and constants of the particle pool update block.
package ppu_pkg;

   typedef enum logic [1:0] {
      MODE_SPAWN = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   localparam logic CSR_PARTICLE_LIMIT = 1'b0;
   localparam logic CSR_GRAVITY_ACCEL  = 1'b1;

   localparam logic [10:0] LIMIT_RESET   = 11'd1024;
   localparam logic [22:0] GRAVITY_RESET = 23'd642253;

   typedef struct packed {
      mode_type           mode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [31:0]        rgba;
      logic [15:0]        sprite_size;
      logic [30:0]        life_span;
      logic [30:0]        delta_t;
      logic [9:0]         read_index;
   } req_type;

   typedef struct packed {
      logic               spawn_taken;
      logic [10:0]        live_count;
      logic               entry_valid;
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_pos_z;
      logic signed [31:0] out_vel_x;
      logic signed [31:0] out_vel_y;
      logic signed [31:0] out_vel_z;
      logic [31:0]        out_rgba;
      logic [15:0]        out_size;
      logic [30:0]        out_life_left;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [31:0]        rgba;
      logic [15:0]        size;
      logic [30:0]        life;
      logic [30:0]        max_life;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPAWN,
      ST_GMUL,
      ST_GSAVE,
      ST_RD,
      ST_LAT,
      ST_MX,
      ST_MY,
      ST_MZ,
      ST_AZ,
      ST_DIV,
      ST_WB,
      ST_RDX,
      ST_RLAT,
      ST_DONE
   } state_type;

endpackage

// File: src/particle_pool_update_top.sv
// Top level of the particle pool: sequencer, shared multiplier, alpha divider and pool memory.
// A tick reads, moves and writes back each live particle in turn; the single shared multiplier
// and the one-bit-per-cycle alpha divider set the time spent on each particle.
// One word is in work at a time; req_ready is high only while the sequencer is idle.
// Reset (synchronous, active high) empties the pool and restores the limit and gravity
// registers; the pool memory itself keeps its contents and is never cleared.
module particle_pool_update_top
   import ppu_pkg::*;
#(
   parameter int MAX_PARTICLES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [22:0] csr_wdata
);

   // Address width of the pool and width of a count that can hold the full depth.
   localparam int AW   = $clog2(MAX_PARTICLES > 1 ? MAX_PARTICLES : 2);
   localparam int CW   = $clog2(MAX_PARTICLES + 1);
   localparam int CMPW = CW > 11 ? CW : 11;
   localparam logic [CMPW-1:0] MAX_CMP = CMPW'(MAX_PARTICLES);

   // Saturate a wide signed sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat_s32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -48'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   logic [10:0]   limit_ff;
   logic [22:0]   gravity_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] keep_ff, keep_in;
   req_type       req_ff;
   entry_type     work_ff, work_in;
   logic signed [64:0] prod_ff, prod_in;
   logic [37:0]   gdrop_ff, gdrop_in;
   rsp_type       res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // Shared multiplier operand.
   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;

   // Memory port.
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   entry_type     ram_wdata, ram_rdata;

   // Divider port.
   logic          div_start, div_done;
   logic [38:0]   div_num;
   logic [7:0]    div_quot;

   logic signed [31:0] life_new;
   logic               room;
   logic               read_hit;
   logic [CW-1:0]      idx_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign mul_b    = $signed({1'b0, req_ff.delta_t});
   assign life_new = $signed({1'b0, work_ff.life}) - $signed({1'b0, req_ff.delta_t});
   assign room     = (CMPW'(count_ff) < CMPW'(limit_ff)) && (CMPW'(count_ff) < MAX_CMP);
   assign read_hit = CMPW'(req_ff.read_index) < CMPW'(count_ff);
   assign idx_next = idx_ff + CW'(1);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LIMIT_RESET;
         gravity_ff <= GRAVITY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PARTICLE_LIMIT: limit_ff   <= csr_wdata[10:0];
            CSR_GRAVITY_ACCEL:  gravity_ff <= csr_wdata;
            default:            limit_ff   <= limit_ff;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.mode)
                  MODE_SPAWN: state_in = ST_SPAWN;
                  MODE_TICK:  state_in = ST_GMUL;
                  MODE_READ:  state_in = ST_RDX;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_SPAWN: state_in = ST_DONE;
         ST_GMUL:  state_in = ST_GSAVE;
         ST_GSAVE: state_in = (count_ff == CW'(0)) ? ST_DONE : ST_RD;
         ST_RD:    state_in = ST_LAT;
         ST_LAT:   state_in = ST_MX;
         ST_MX:    state_in = ST_MY;
         ST_MY:    state_in = ST_MZ;
         ST_MZ:    state_in = ST_AZ;
         ST_AZ:    state_in = ST_DIV;
         ST_DIV:   state_in = div_done ? ST_WB : ST_DIV;
         ST_WB:    state_in = (idx_next == count_ff) ? ST_DONE : ST_RD;
         ST_RDX:   state_in = ST_RLAT;
         ST_RLAT:  state_in = ST_DONE;
         ST_DONE:  state_in = (!rsp_valid_ff || rsp_ready) ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs of each state.
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      keep_in      = keep_ff;
      work_in      = work_ff;
      prod_in      = prod_ff;
      gdrop_in     = gdrop_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_a        = 33'sd0;
      ram_we       = 1'b0;
      ram_waddr    = keep_ff[AW-1:0];
      ram_wdata    = work_ff;
      ram_raddr    = idx_ff[AW-1:0];
      div_start    = 1'b0;
      div_num      = {life_new[30:0], 8'd0} - {8'd0, life_new[30:0]};

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            res_in = '0;
         end
         ST_SPAWN: begin
            if (room) begin
               ram_we             = 1'b1;
               ram_waddr          = count_ff[AW-1:0];
               ram_wdata.pos_x    = req_ff.pos_x;
               ram_wdata.pos_y    = req_ff.pos_y;
               ram_wdata.pos_z    = req_ff.pos_z;
               ram_wdata.vel_x    = req_ff.vel_x;
               ram_wdata.vel_y    = req_ff.vel_y;
               ram_wdata.vel_z    = req_ff.vel_z;
               ram_wdata.rgba     = req_ff.rgba;
               ram_wdata.size     = req_ff.sprite_size;
               ram_wdata.life     = req_ff.life_span;
               ram_wdata.max_life = req_ff.life_span;
               count_in           = count_ff + CW'(1);
               res_in.spawn_taken = 1'b1;
            end
         end
         ST_GMUL: begin
            mul_a   = $signed({10'd0, gravity_ff});
            prod_in = mul_a * mul_b;
            idx_in  = '0;
            keep_in = '0;
         end
         ST_GSAVE: begin
            gdrop_in = prod_ff[53:16];
         end
         ST_RD: begin
            ram_raddr = idx_ff[AW-1:0];
         end
         ST_LAT: begin
            work_in = ram_rdata;
         end
         ST_MX: begin
            mul_a   = 33'(work_ff.vel_x);
            prod_in = mul_a * mul_b;
         end
         ST_MY: begin
            mul_a         = 33'(work_ff.vel_y);
            prod_in       = mul_a * mul_b;
            work_in.pos_x = sat_s32(48'(work_ff.pos_x) + prod_ff[63:16]);
         end
         ST_MZ: begin
            mul_a         = 33'(work_ff.vel_z);
            prod_in       = mul_a * mul_b;
            work_in.pos_y = sat_s32(48'(work_ff.pos_y) + prod_ff[63:16]);
         end
         ST_AZ: begin
            work_in.pos_z = sat_s32(48'(work_ff.pos_z) + prod_ff[63:16]);
            work_in.vel_y = sat_s32(48'(work_ff.vel_y) - $signed({10'd0, gdrop_ff}));
            // An expired particle keeps a life of zero, which marks it for removal.
            work_in.life  = life_new[31] ? 31'd0 : life_new[30:0];
            div_start     = 1'b1;
         end
         ST_DIV: begin
            // The divider computes floor(255 * life / max_life) in the background.
         end
         ST_WB: begin
            // Survivors are packed down to the keep position; the rest vanish.
            ram_wdata.rgba = {work_ff.rgba[31:8], div_quot};
            if (work_ff.life != 31'd0) begin
               ram_we  = 1'b1;
               keep_in = keep_ff + CW'(1);
            end
            idx_in = idx_next;
            if (idx_next == count_ff) begin
               count_in = keep_in;
            end
         end
         ST_RDX: begin
            ram_raddr = AW'(req_ff.read_index);
         end
         ST_RLAT: begin
            if (read_hit) begin
               res_in.entry_valid   = 1'b1;
               res_in.out_pos_x     = ram_rdata.pos_x;
               res_in.out_pos_y     = ram_rdata.pos_y;
               res_in.out_pos_z     = ram_rdata.pos_z;
               res_in.out_vel_x     = ram_rdata.vel_x;
               res_in.out_vel_y     = ram_rdata.vel_y;
               res_in.out_vel_z     = ram_rdata.vel_z;
               res_in.out_rgba      = ram_rdata.rgba;
               res_in.out_size      = ram_rdata.size;
               res_in.out_life_left = ram_rdata.life;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in            = res_ff;
               rsp_data_in.live_count = 11'(count_ff);
            end
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   // In the write-back state the work register already holds the ticked life,
   // so the keep test above looks at the stored value: a survivor has life above zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         keep_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      work_ff     <= work_in;
      prod_ff     <= prod_in;
      gdrop_ff    <= gdrop_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   ppu_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(MAX_PARTICLES)
   ) u_pool (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   ppu_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(work_ff.max_life),
      .quot(div_quot),
      .done(div_done)
   );

   // The pool never holds more particles than it has entries.
   assert property (@(posedge clock) disable iff (reset) CMPW'(count_ff) <= MAX_CMP)
      else $error("pool count exceeds depth");

   // Compaction never writes ahead of the entry being read.
   assert property (@(posedge clock) disable iff (reset) keep_ff <= idx_ff || state_ff == ST_SPAWN
                    || state_ff == ST_IDLE || state_ff == ST_DONE || state_ff == ST_RDX
                    || state_ff == ST_RLAT || state_ff == ST_GMUL || state_ff == ST_GSAVE)
      else $error("keep index passed read index");

   // Accepting a word always takes the block out of idle for the next cycle.
   assert property (@(posedge clock) disable iff (reset) req_valid && req_ready |=> !req_ready)
      else $error("accepted two words back to back");

   // A taken spawn always leaves at least one live particle behind.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_data.spawn_taken |-> rsp_data.live_count != 11'd0)
      else $error("spawn taken with empty pool");

endmodule

// File: src/ppu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/ppu_div.sv
// Restoring divider that yields an eight-bit quotient, one bit per cycle.
module ppu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [38:0] num,
   input  logic [30:0] den,
   output logic [7:0]  quot,
   output logic        done
);

   logic [38:0] rem_ff, rem_in;
   logic [38:0] den_ff, den_in;
   logic [7:0]  quo_ff, quo_in;
   logic [2:0]  step_ff, step_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [39:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {1'b0, rem_ff} - {1'b0, den_ff};
      if (start) begin
         rem_in  = num;
         den_in  = {1'b0, den, 7'd0};
         quo_in  = 8'd0;
         step_in = 3'd0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (!trial[39]) begin
            rem_in = trial[38:0];
            quo_in = {quo_ff[6:0], 1'b1};
         end else begin
            quo_in = {quo_ff[6:0], 1'b0};
         end
         den_in  = den_ff >> 1;
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd7) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quot = quo_ff;
   assign done = done_ff;

endmodule
